// File: sv/ckdc_pkg.sv
package ckdc_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_K = 32;
    localparam int KMER_W = 64;
    localparam int COUNT_MAX = 2047;
    localparam logic [5:0] KMER_LEN_RESET = 6'd20;

    // lowercase codes; input is folded to lowercase by CASE_BIT
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_C = 8'h63;
    localparam logic [7:0] CHAR_G = 8'h67;
    localparam logic [7:0] CHAR_T = 8'h74;
    localparam logic [1:0] COMP_MASK = 2'd3;

    typedef struct packed {
        logic [KMER_W-1:0] canon;
        logic              insert;
        logic              last;
        logic              short_read;
    } ckdc_job_t;

    typedef struct packed {
        logic signed [11:0] distinct_count;
        logic               table_overflow;
    } ckdc_result_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_EMIT,
        S_FLUSH
    } ckdc_state_t;

endpackage

// File: sv/ckdc_if.sv
interface ckdc_base_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic       last_of_read;
    modport source (output valid, output base_char, output last_of_read, input ready);
    modport sink (input valid, input base_char, input last_of_read, output ready);
endinterface

interface ckdc_count_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] distinct_count;
    logic              table_overflow;
    modport source (output valid, output distinct_count, output table_overflow, input ready);
    modport sink (input valid, input distinct_count, input table_overflow, output ready);
endinterface

interface ckdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/canonical_kmer_distinct_counter.sv
// Base item: registered as a job by the roller; one with a k-mer to store then
// probes the linearly probed hash table, a read and a check state per probe.
// Last item of a read: result registered in S_EMIT after any probe (held while a
// previous result waits), then used slots are cleared before a new item is taken.
// Reset: asynchronous, active low; a clearing pass over all TABLE_DEPTH slots
// follows reset, during which no item is accepted (config writes are).
module canonical_kmer_distinct_counter #(
    parameter int TABLE_DEPTH = ckdc_pkg::TABLE_DEPTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    ckdc_cfg_if.sink   cfg,
    ckdc_base_if.sink  bases,
    ckdc_count_if.source counts
);
    import ckdc_pkg::*;

    ckdc_job_t    job;
    logic         job_valid;
    logic         table_idle;
    ckdc_result_t result;
    logic         accept;

    assign cfg.ready = 1'b1;
    assign bases.ready = table_idle && !job_valid;
    assign accept = bases.valid && bases.ready;

    ckdc_roller u_roller (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_data     (cfg.data),
        .accept       (accept),
        .base_char    (bases.base_char),
        .last_of_read (bases.last_of_read),
        .job          (job),
        .job_valid    (job_valid)
    );

    ckdc_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_valid    (job_valid),
        .idle         (table_idle),
        .result       (result),
        .result_valid (counts.valid),
        .result_take  (counts.ready)
    );

    assign counts.distinct_count = result.distinct_count;
    assign counts.table_overflow = result.table_overflow;

endmodule

// File: sv/ckdc_ram.sv
module ckdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: sv/ckdc_roller.sv
module ckdc_roller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [5:0]          cfg_data,
    input  logic                accept,
    input  logic [7:0]          base_char,
    input  logic                last_of_read,
    output ckdc_pkg::ckdc_job_t job,
    output logic                job_valid
);
    import ckdc_pkg::*;

    logic [5:0]        kmer_length_reg;
    logic [KMER_W-1:0] fwd_reg, fwd_next;
    logic [KMER_W-1:0] rev_reg, rev_next;
    logic [5:0]        run_reg, run_next;
    logic [5:0]        len_reg, len_next;
    ckdc_job_t         job_reg, job_next;
    logic              job_valid_reg;

    logic [5:0]        k;
    logic [6:0]        run_inc, len_inc;
    logic [1:0]        code;
    logic              code_ok;
    logic [KMER_W-1:0] mask;

    always_comb
    begin
        if (kmer_length_reg == 6'd0)
            k = 6'd1;
        else if (32'(kmer_length_reg) > MAX_K)
            k = 6'(MAX_K);
        else
            k = kmer_length_reg;
    end

    always_comb
    begin
        code_ok = 1'b1;
        case (base_char | CASE_BIT)
            CHAR_A:  code = 2'd0;
            CHAR_C:  code = 2'd1;
            CHAR_G:  code = 2'd2;
            CHAR_T:  code = 2'd3;
            default:
            begin
                code = 2'd0;
                code_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mask = (k >= 6'd32) ? '1 : ((KMER_W'(1) << {k, 1'b0}) - KMER_W'(1));
        len_inc = {1'b0, len_reg} + 7'd1;
        run_inc = {1'b0, run_reg} + 7'd1;
        len_next = (len_inc >= {1'b0, k}) ? k : len_inc[5:0];
        fwd_next = fwd_reg;
        rev_next = rev_reg;
        run_next = 6'd0;
        if (code_ok)
        begin
            fwd_next = ((fwd_reg << 2) | KMER_W'(code)) & mask;
            rev_next = (KMER_W'(code ^ COMP_MASK) << {k - 6'd1, 1'b0}) | (rev_reg >> 2);
            run_next = (run_inc >= {1'b0, k}) ? k : run_inc[5:0];
        end
        job_next.canon = (fwd_next < rev_next) ? fwd_next : rev_next;
        job_next.insert = code_ok && (run_next >= k);
        job_next.last = last_of_read;
        job_next.short_read = len_next < k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_LEN_RESET;
            fwd_reg <= '0;
            rev_reg <= '0;
            run_reg <= '0;
            len_reg <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                kmer_length_reg <= cfg_data;
            end
            job_valid_reg <= accept;
            if (accept)
            begin
                if (last_of_read)
                begin
                    fwd_reg <= '0;
                    rev_reg <= '0;
                    run_reg <= '0;
                    len_reg <= '0;
                end
                else
                begin
                    fwd_reg <= fwd_next;
                    rev_reg <= rev_next;
                    run_reg <= run_next;
                    len_reg <= len_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job = job_reg;
    assign job_valid = job_valid_reg;

endmodule

// File: sv/ckdc_table.sv
module ckdc_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ckdc_pkg::ckdc_job_t    job,
    input  logic                   job_valid,
    output logic                   idle,
    output ckdc_pkg::ckdc_result_t result,
    output logic                   result_valid,
    input  logic                   result_take
);
    import ckdc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NCH = (KMER_W + AW - 1) / AW;
    localparam int HW = KMER_W + 1;

    ckdc_state_t state_reg, state_next;

    logic [KMER_W-1:0] canon_reg, canon_next;
    logic              last_reg, last_next;
    logic              short_reg, short_next;
    logic              ovf_reg, ovf_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     probes_reg, probes_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     flush_idx_reg, flush_idx_next;
    logic              flush_pend_reg, flush_pend_next;
    logic [AW-1:0]     init_idx_reg, init_idx_next;
    ckdc_result_t      res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic              h_we;
    logic [AW-1:0]     h_waddr, h_raddr;
    logic [HW-1:0]     h_wdata, h_rdata;
    logic              l_we;
    logic [AW-1:0]     l_waddr, l_raddr, l_rdata;

    logic [NCH*AW-1:0] padded;
    logic [AW-1:0]     fold;
    logic [AW-1:0]     hash_idx;
    logic              hit, empty_slot, last_probe;
    logic [AW-1:0]     addr_inc;
    logic              slot_free;

    // fold the k-mer into a table index
    always_comb
    begin
        padded = (NCH * AW)'(job.canon);
        fold = '0;
        for (int i = 0; i < NCH; i++)
        begin
            fold = fold ^ padded[i*AW +: AW];
        end
        if ({1'b0, fold} >= (AW + 1)'(TABLE_DEPTH))
            hash_idx = AW'({1'b0, fold} - (AW + 1)'(TABLE_DEPTH));
        else
            hash_idx = fold;
    end

    assign hit = h_rdata[KMER_W] && (h_rdata[KMER_W-1:0] == canon_reg);
    assign empty_slot = !h_rdata[KMER_W];
    assign last_probe = probes_reg == CW'(TABLE_DEPTH - 1);
    assign addr_inc = (addr_reg == AW'(TABLE_DEPTH - 1)) ? '0 : addr_reg + AW'(1);
    assign slot_free = !res_valid_reg || result_take;

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        canon_next = canon_reg;
        last_next = last_reg;
        short_next = short_reg;
        ovf_next = ovf_reg;
        addr_next = addr_reg;
        probes_next = probes_reg;
        count_next = count_reg;
        flush_idx_next = flush_idx_reg;
        flush_pend_next = flush_pend_reg;
        init_idx_next = init_idx_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg && !result_take;
        case (state_reg)
            S_INIT:
            begin
                init_idx_next = init_idx_reg + AW'(1);
                if (init_idx_reg == AW'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (job_valid)
                begin
                    canon_next = job.canon;
                    last_next = job.last;
                    short_next = job.short_read;
                    addr_next = hash_idx;
                    probes_next = '0;
                    if (job.insert)
                        state_next = S_READ;
                    else if (job.last)
                        state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (hit || empty_slot || last_probe)
                begin
                    if (!hit && empty_slot)
                        count_next = count_reg + CW'(1);
                    else if (!hit)
                        ovf_next = 1'b1;
                    state_next = last_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    addr_next = addr_inc;
                    probes_next = probes_reg + CW'(1);
                    state_next = S_READ;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_next.table_overflow = ovf_reg;
                    if (short_reg)
                        res_next.distinct_count = -12'sd1;
                    else if (32'(count_reg) > COUNT_MAX)
                        res_next.distinct_count = 12'(COUNT_MAX);
                    else
                        res_next.distinct_count = {1'b0, 11'(count_reg)};
                    flush_idx_next = '0;
                    flush_pend_next = 1'b0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                flush_pend_next = flush_idx_reg < count_reg;
                if (flush_idx_reg < count_reg)
                    flush_idx_next = flush_idx_reg + CW'(1);
                else if (!flush_pend_reg)
                begin
                    count_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        h_we = 1'b0;
        h_waddr = addr_reg;
        h_wdata = {1'b1, canon_reg};
        h_raddr = addr_reg;
        l_we = 1'b0;
        l_waddr = AW'(count_reg);
        l_raddr = AW'(flush_idx_reg);
        case (state_reg)
            S_INIT:
            begin
                h_we = 1'b1;
                h_waddr = init_idx_reg;
                h_wdata = '0;
            end
            S_CHECK:
            begin
                if (!hit && empty_slot)
                begin
                    h_we = 1'b1;
                    l_we = 1'b1;
                end
            end
            S_FLUSH:
            begin
                h_we = flush_pend_reg;
                h_waddr = l_rdata;
                h_wdata = '0;
            end
            default:
            begin
                h_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_idx_reg <= '0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            probes_reg <= '0;
            flush_idx_reg <= '0;
            flush_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_idx_reg <= init_idx_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            probes_reg <= probes_next;
            flush_idx_reg <= flush_idx_next;
            flush_pend_reg <= flush_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        canon_reg <= canon_next;
        last_reg <= last_next;
        short_reg <= short_next;
        addr_reg <= addr_next;
        res_reg <= res_next;
    end

    ckdc_ram #(.WIDTH(HW), .DEPTH(TABLE_DEPTH)) u_hash_ram (
        .clk     (clk),
        .wr_en   (h_we),
        .wr_addr (h_waddr),
        .wr_data (h_wdata),
        .rd_addr (h_raddr),
        .rd_data (h_rdata)
    );

    // fill-order list of used slots, walked to clear them at end of read
    ckdc_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_list_ram (
        .clk     (clk),
        .wr_en   (l_we),
        .wr_addr (l_waddr),
        .wr_data (addr_reg),
        .rd_addr (l_raddr),
        .rd_data (l_rdata)
    );

    assign idle = state_reg == S_IDLE;
    assign result = res_reg;
    assign result_valid = res_valid_reg;

endmodule
